/* rtl/bezier_curve_point_eval_unit_assert.svh */
// assertion macros for the bezier point unit, sampled on aclk, off while in reset
`ifndef BEZIER_CURVE_POINT_EVAL_UNIT_ASSERT_SVH
`define BEZIER_CURVE_POINT_EVAL_UNIT_ASSERT_SVH

// same-cycle implication
`define BCPE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bcpe same-cycle check failed");

// next-cycle implication
`define BCPE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bcpe next-cycle check failed");

`endif

/* rtl/bcpe_pkg.sv */
`default_nettype none

package bcpe_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 24;
    localparam int IDX_BITS   = 10;
    localparam int DEG_BITS   = 2;
    localparam int NUM_PTS    = 4;

    localparam int FX_BITS   = FRAC_BITS + 1;
    localparam int W_BITS    = FRAC_BITS + 2;
    localparam int PROD_BITS = COORD_BITS + W_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int ACC_BITS  = PROD_BITS + 2;

    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = FRAC_BITS / DIV_STEP;

    localparam int S_TDATA_BITS = ((IDX_BITS + 2 * NUM_PTS * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    localparam logic [IDX_BITS-1:0] RES_RESET = IDX_BITS'(100);
    localparam logic [FX_BITS-1:0]  FX_ONE    = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [ACC_BITS-1:0] TRUNC_BIAS =
        {{(ACC_BITS-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    localparam logic [DEG_BITS-1:0] DEG_LINEAR = DEG_BITS'(1);
    localparam logic [DEG_BITS-1:0] DEG_QUAD   = DEG_BITS'(2);

    typedef logic [FX_BITS-1:0] fx_t;
    typedef logic [W_BITS-1:0]  weight_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } point_t;

    typedef struct packed {
        logic [DEG_BITS-1:0]       degree;
        point_t [NUM_PTS-1:0]      pts;
    } item_t;

    typedef struct packed {
        logic [PROD_BITS-1:0] y;
        logic [PROD_BITS-1:0] x;
    } prod_t;

    function automatic fx_t fx_mul(input fx_t a, input fx_t b);
        logic [2*FX_BITS-1:0] p;
        p = a * b;
        return p[FRAC_BITS +: FX_BITS];
    endfunction

endpackage

`default_nettype wire

/* rtl/bcpe_div.sv */
`default_nettype none

module bcpe_div
    import bcpe_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire [IDX_BITS-1:0]  resolution,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire [IDX_BITS-1:0]  in_index,
    input  wire item_t          in_item,
    output logic                out_valid,
    input  wire                 out_ready,
    output fx_t                 out_t,
    output item_t               out_item
);

    logic [IDX_BITS-1:0] res_eff;
    logic [DIV_STAGES:0]   v_reg;
    logic [DIV_STAGES:0]   ld;
    logic [DIV_STAGES+1:0] rdy;

    logic [IDX_BITS-1:0] rem_reg  [DIV_STAGES+1];
    logic [IDX_BITS-1:0] rem_next [DIV_STAGES+1];
    fx_t                 q_reg    [DIV_STAGES+1];
    fx_t                 q_next   [DIV_STAGES+1];
    item_t               item_reg [DIV_STAGES+1];

    assign res_eff = (resolution == '0) ? IDX_BITS'(1) : resolution;

    always_comb begin
        rdy[DIV_STAGES+1] = out_ready;
        for (int i = DIV_STAGES; i >= 0; i--) begin
            ld[i]  = !v_reg[i] || rdy[i+1];
            rdy[i] = ld[i];
        end
    end

    assign in_ready = rdy[0];

    // clamp, integer quotient bit, then DIV_STEP quotient bits per stage
    always_comb begin
        logic [IDX_BITS-1:0] idx_c;
        logic [IDX_BITS-1:0] r;
        logic [IDX_BITS:0]   r2;
        fx_t                 q;
        idx_c       = (in_index > res_eff) ? res_eff : in_index;
        rem_next[0] = (idx_c == res_eff) ? '0 : idx_c;
        q_next[0]   = FX_BITS'(idx_c == res_eff);
        for (int i = 1; i <= DIV_STAGES; i++) begin
            r = rem_reg[i-1];
            q = q_reg[i-1];
            for (int j = 0; j < DIV_STEP; j++) begin
                r2 = {r, 1'b0};
                if (r2 >= {1'b0, res_eff}) begin
                    r2 = r2 - {1'b0, res_eff};
                    q  = {q[FX_BITS-2:0], 1'b1};
                end else begin
                    q  = {q[FX_BITS-2:0], 1'b0};
                end
                r = r2[IDX_BITS-1:0];
            end
            rem_next[i] = r;
            q_next[i]   = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i <= DIV_STAGES; i++) begin
                if (ld[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            item_reg[0] <= in_item;
        end
        for (int i = 1; i <= DIV_STAGES; i++) begin
            if (ld[i]) begin
                rem_reg[i]  <= rem_next[i];
                q_reg[i]    <= q_next[i];
                item_reg[i] <= item_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES];
    assign out_t     = q_reg[DIV_STAGES];
    assign out_item  = item_reg[DIV_STAGES];

endmodule

`default_nettype wire

/* rtl/bcpe_weight.sv */
`default_nettype none

module bcpe_weight
    import bcpe_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire fx_t                in_t,
    input  wire item_t              in_item,
    output logic                    out_valid,
    input  wire                     out_ready,
    output weight_t [NUM_PTS-1:0]   out_w,
    output item_t                   out_item
);

    logic  v1_reg, v2_reg;
    logic  ld1, ld2;
    fx_t   u_next;
    fx_t   t1_reg, u1_reg, uu1_reg, tt1_reg, tu1_reg;
    item_t item1_reg, item2_reg;
    fx_t   uuu, tuu, ttu, ttt;
    weight_t [NUM_PTS-1:0] w2_next, w2_reg;

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;
    assign u_next   = FX_ONE - in_t;

    // second products from the registered squares
    assign uuu = fx_mul(uu1_reg, u1_reg);
    assign tuu = fx_mul(t1_reg, uu1_reg);
    assign ttu = fx_mul(tt1_reg, u1_reg);
    assign ttt = fx_mul(tt1_reg, t1_reg);

    always_comb begin
        case (item1_reg.degree)
            DEG_LINEAR: begin
                w2_next[0] = W_BITS'(u1_reg);
                w2_next[1] = W_BITS'(t1_reg);
                w2_next[2] = '0;
                w2_next[3] = '0;
            end
            DEG_QUAD: begin
                w2_next[0] = W_BITS'(uu1_reg);
                w2_next[1] = {tu1_reg, 1'b0};
                w2_next[2] = W_BITS'(tt1_reg);
                w2_next[3] = '0;
            end
            default: begin
                w2_next[0] = W_BITS'(uuu);
                w2_next[1] = {tuu, 1'b0} + W_BITS'(tuu);
                w2_next[2] = {ttu, 1'b0} + W_BITS'(ttu);
                w2_next[3] = W_BITS'(ttt);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ld1) begin
                v1_reg <= in_valid;
            end
            if (ld2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            t1_reg    <= in_t;
            u1_reg    <= u_next;
            uu1_reg   <= fx_mul(u_next, u_next);
            tt1_reg   <= fx_mul(in_t, in_t);
            tu1_reg   <= fx_mul(in_t, u_next);
            item1_reg <= in_item;
        end
        if (ld2) begin
            w2_reg    <= w2_next;
            item2_reg <= item1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_w     = w2_reg;
    assign out_item  = item2_reg;

endmodule

`default_nettype wire

/* rtl/bcpe_lane.sv */
`default_nettype none

module bcpe_lane
    import bcpe_pkg::*;
(
    input  wire          aclk,
    input  wire          load,
    input  wire point_t  p,
    input  wire weight_t w,
    output prod_t        prod
);

    logic signed [PROD_BITS:0] mx, my;
    prod_t prod_next, prod_reg;

    assign mx = $signed(p.x) * $signed({1'b0, w});
    assign my = $signed(p.y) * $signed({1'b0, w});

    assign prod_next.x = mx[PROD_BITS-1:0];
    assign prod_next.y = my[PROD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/bcpe_merge.sv */
`default_nettype none

module bcpe_merge
    import bcpe_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire prod_t [NUM_PTS-1:0] in_prod,
    output logic                  out_valid,
    input  wire                   out_ready,
    output point_t                out_point
);

    logic v1_reg, v2_reg, v3_reg;
    logic ld1, ld2, ld3;

    logic signed [SUM_BITS-1:0] sx01_reg, sx23_reg, sy01_reg, sy23_reg;
    logic signed [ACC_BITS-1:0] accx_reg, accy_reg;
    logic signed [ACC_BITS-1:0] bx, by;
    point_t point_next, point_reg;

    assign ld3      = !v3_reg || out_ready;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // divide by one fixed-point unit, rounding toward zero
    assign bx = accx_reg + (accx_reg[ACC_BITS-1] ? TRUNC_BIAS : '0);
    assign by = accy_reg + (accy_reg[ACC_BITS-1] ? TRUNC_BIAS : '0);
    assign point_next.x = bx[FRAC_BITS +: COORD_BITS];
    assign point_next.y = by[FRAC_BITS +: COORD_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ld1) begin
                v1_reg <= in_valid;
            end
            if (ld2) begin
                v2_reg <= v1_reg;
            end
            if (ld3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            sx01_reg <= SUM_BITS'($signed(in_prod[0].x)) + SUM_BITS'($signed(in_prod[1].x));
            sx23_reg <= SUM_BITS'($signed(in_prod[2].x)) + SUM_BITS'($signed(in_prod[3].x));
            sy01_reg <= SUM_BITS'($signed(in_prod[0].y)) + SUM_BITS'($signed(in_prod[1].y));
            sy23_reg <= SUM_BITS'($signed(in_prod[2].y)) + SUM_BITS'($signed(in_prod[3].y));
        end
        if (ld2) begin
            accx_reg <= ACC_BITS'(sx01_reg) + ACC_BITS'(sx23_reg);
            accy_reg <= ACC_BITS'(sy01_reg) + ACC_BITS'(sy23_reg);
        end
        if (ld3) begin
            point_reg <= point_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_point = point_reg;

endmodule

`default_nettype wire

/* rtl/bezier_curve_point_eval_unit.sv */
`default_nettype none

// Cubic, quadratic or linear Bezier point evaluator. Each transfer on the s_ side carries a
// step index, a degree in s_tuser and four control points; one curve point comes out on the
// m_ side for each, in order, with t = index / resolution (index clamped to resolution,
// resolution 0 taken as 1) in unsigned fixed point with 24 fractional bits, and coordinates
// truncated toward zero. The unit takes one item per clock unless m_tready holds it back, and
// keeps up to thirteen in flight; an item passes the pipelined t divider (integer bit, then four
// quotient bits per stage), the Bernstein weights, the four multiply lanes and then the merging
// adder tree and output register. Resolution is written on the cfg_ channel (reset value 100)
// and must only change while no item is in flight.

`include "bezier_curve_point_eval_unit_assert.svh"

module bezier_curve_point_eval_unit
    import bcpe_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    // step_index, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, zero fill
    input  wire [S_TDATA_BITS-1:0]  s_tdata,
    // degree
    input  wire [DEG_BITS-1:0]      s_tuser,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    // point_x, point_y
    output logic [M_TDATA_BITS-1:0] m_tdata,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire [IDX_BITS-1:0]      cfg_data
);

    logic [IDX_BITS-1:0] resolution_reg;
    item_t in_item;

    logic  div_valid, div_ready;
    fx_t   div_t;
    item_t div_item;

    logic  wgt_valid, wgt_ready;
    weight_t [NUM_PTS-1:0] wgt_w;
    item_t wgt_item;
    logic [W_BITS+1:0] wgt_sum;

    logic  lane_v_reg, lane_ld;
    prod_t [NUM_PTS-1:0] lane_prod;

    logic   mrg_ready;
    point_t out_point;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resolution_reg <= RES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            resolution_reg <= cfg_data;
        end
    end

    always_comb begin
        in_item.degree = s_tuser;
        for (int k = 0; k < NUM_PTS; k++) begin
            in_item.pts[k].x = s_tdata[IDX_BITS + 2*k*COORD_BITS +: COORD_BITS];
            in_item.pts[k].y = s_tdata[IDX_BITS + (2*k+1)*COORD_BITS +: COORD_BITS];
        end
    end

    bcpe_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .resolution (resolution_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_index   (s_tdata[IDX_BITS-1:0]),
        .in_item    (in_item),
        .out_valid  (div_valid),
        .out_ready  (div_ready),
        .out_t      (div_t),
        .out_item   (div_item)
    );

    bcpe_weight u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_t      (div_t),
        .in_item   (div_item),
        .out_valid (wgt_valid),
        .out_ready (wgt_ready),
        .out_w     (wgt_w),
        .out_item  (wgt_item)
    );

    assign lane_ld   = !lane_v_reg || mrg_ready;
    assign wgt_ready = lane_ld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_v_reg <= 1'b0;
        end else if (lane_ld) begin
            lane_v_reg <= wgt_valid;
        end
    end

    for (genvar k = 0; k < NUM_PTS; k++) begin : g_lane
        bcpe_lane u_lane (
            .aclk (aclk),
            .load (lane_ld),
            .p    (wgt_item.pts[k]),
            .w    (wgt_w[k]),
            .prod (lane_prod[k])
        );
    end

    bcpe_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lane_v_reg),
        .in_ready  (mrg_ready),
        .in_prod   (lane_prod),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_point (out_point)
    );

    assign m_tdata = {out_point.y, out_point.x};

    assign wgt_sum = (W_BITS+2)'(wgt_w[0]) + (W_BITS+2)'(wgt_w[1])
                   + (W_BITS+2)'(wgt_w[2]) + (W_BITS+2)'(wgt_w[3]);

    // input stalls only when every stage up to the output is full
    `BCPE_ASSERT_IMP(a_stall_source, !s_tready, m_tvalid && !m_tready)
    `BCPE_ASSERT_IMP(a_t_range, div_valid, div_t <= FX_ONE)
    `BCPE_ASSERT_IMP(a_weight_sum, wgt_valid, wgt_sum <= (W_BITS+2)'(FX_ONE))

endmodule

`default_nettype wire
